// ===== hw/rtl/pgi_pkg.sv =====
// Shared types and constants for the palette gradient interpolator.
`default_nettype none
package pgi_pkg;

  localparam int PALETTE_DEPTH_DEF = 16;
  localparam int FRAC_BITS_DEF     = 16;

  localparam int MAG_W = 20;   // signed magnitude
  localparam int IDX_W = 4;    // palette write index
  localparam int CH_W  = 9;    // one color channel
  localparam int CNT_W = 5;    // color_count register

  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_CYCLIC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 1'd1;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  localparam int COUNT_RESET = 5;

  // Stage enables handed to the channel lanes.
  typedef struct packed {
    logic d;   // blend product stage loads
    logic e;   // result stage loads
  } pgi_adv_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pgi_ram.sv =====
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module pgi_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pgi_lane.sv =====
// One color channel: difference times fraction, then shift and add.
`default_nettype none
module pgi_lane
  import pgi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire pgi_adv_t             adv,
  input  wire logic [CH_W-1:0]      lo,
  input  wire logic [CH_W-1:0]      hi,
  input  wire logic [FRAC_BITS:0]   frac,
  output logic      [CH_W-1:0]      result
);

  localparam int DW = CH_W + 1;
  localparam int FW = FRAC_BITS + 2;
  localparam int PW = DW + FW;

  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] d_prod;
  logic        [CH_W-1:0] d_lo;
  logic signed [PW-1:0] sum;

  // a*(1-f) + b*f == a*ONE + (b-a)*f; the arithmetic shift floors
  always_comb begin
    diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
    prod = PW'(diff) * PW'($signed({1'b0, frac}));
    sum  = $signed(PW'({1'b0, d_lo})) + (d_prod >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (adv.d) begin
      d_prod <= prod;
      d_lo   <= lo;
    end
    if (adv.e) begin
      result <= sum[CH_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/palette_gradient_interpolator_unit.sv =====
// Palette gradient interpolator: magnitude to RGB through a loadable palette.
//
// Input stream s_*: s_tuser is the command (0 lookup, 1 palette write).
// A write stores red_in/green_in/blue_in at entry_index and gives no output;
// an index not below PALETTE_DEPTH is dropped. A lookup gives one m_* transfer
// with the interpolated red, green and blue channels.
// Config channel cfg_*: index 0 = cyclic_mode, 1 = color_count; cfg_ready is
// always high. Write it only while the pipeline is empty.
// Throughput: one item per cycle while m_tready does not hold the output; the
// five register stages (clamp, multiply, palette read, blend product, result)
// each hold their own valid bit.
// Palette reads use the registered read of a two-read-port RAM.
// Stalls: each stage takes a new item when it is empty or its successor moves,
// so bubbles are squeezed out and the block keeps accepting while a result
// waits; nothing is dropped or repeated.
// Reset: empties the pipeline, cyclic_mode = 0, color_count = 5. Palette
// contents are undefined until written; there is no clearing pass.
`default_nettype none
module palette_gradient_interpolator_unit
  import pgi_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // [19:0] magnitude, [23:20] entry_index, [32:24] red_in,
  // [41:33] green_in, [50:42] blue_in, [55:51] zero
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  // [0] command
  input  wire logic                  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [8:0] red, [17:9] green, [26:18] blue, [31:27] zero
  output logic      [M_TDATA_W-1:0]  m_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW      = $clog2(PALETTE_DEPTH);
  localparam int MB      = FRAC_BITS + 1;
  localparam int CW      = (MAG_W > FRAC_BITS + 2) ? MAG_W : FRAC_BITS + 2;
  localparam int PW      = MB + CNT_W;
  localparam int CNT_MAX = (PALETTE_DEPTH < 31) ? PALETTE_DEPTH : 31;
  localparam int RW      = 3 * CH_W;

  localparam logic [CW-1:0] ONE_C  = CW'(1) << FRAC_BITS;
  localparam logic [MB-1:0] ONE_M  = MB'(1) << FRAC_BITS;
  localparam logic [MB-1:0] HALF_M = MB'(1) << (FRAC_BITS - 1);

  function automatic logic [CNT_W-1:0] spans_of(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] c;
    c = cnt;
    if (c < CNT_W'(2)) begin
      c = CNT_W'(2);
    end else if (c > CNT_W'(CNT_MAX)) begin
      c = CNT_W'(CNT_MAX);
    end
    return c - CNT_W'(1);
  endfunction

  // configuration
  logic             cyclic;
  logic [CNT_W-1:0] spans;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cyclic <= 1'b0;
      spans  <= spans_of(CNT_W'(COUNT_RESET));
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CYCLIC: cyclic <= cfg_data[0];
        CFG_COUNT:  spans  <= spans_of(cfg_data);
        default: ;
      endcase
    end
  end

  // stage valids and ready chain
  logic a_v, b_v, c_v, d_v, e_v;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

  assign rdy_e    = !e_v || m_tready;
  assign rdy_d    = !d_v || rdy_e;
  assign rdy_c    = !c_v || rdy_d;
  assign rdy_b    = !b_v || rdy_c;
  assign rdy_a    = !a_v || rdy_b;
  assign s_tready = rdy_a;
  assign m_tvalid = e_v;

  // stage A: clamp and mirror
  logic [MAG_W-1:0] mag;
  logic [CW-1:0]    raw_c;
  logic [MB-1:0]    m_clamp;
  logic [MB-1:0]    m_eff;

  assign mag   = s_tdata[MAG_W-1:0];
  assign raw_c = CW'(mag[MAG_W-2:0]);

  always_comb begin
    if (mag[MAG_W-1]) begin
      m_clamp = '0;
    end else if (raw_c > ONE_C) begin
      m_clamp = ONE_M;
    end else begin
      m_clamp = MB'(raw_c);
    end
    m_eff = (cyclic && m_clamp > HALF_M) ? ONE_M - m_clamp : m_clamp;
  end

  logic             a_cmd;
  logic [MB-1:0]    a_m;
  logic [IDX_W-1:0] a_idx;
  logic [RW-1:0]    a_rgb;

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_cmd <= s_tuser;
      a_m   <= m_eff;
      a_idx <= s_tdata[MAG_W+IDX_W-1:MAG_W];
      a_rgb <= s_tdata[MAG_W+IDX_W+RW-1:MAG_W+IDX_W];
    end
  end

  // stage B: position times span count
  logic             b_cmd;
  logic [PW-1:0]    b_p;
  logic [IDX_W-1:0] b_idx;
  logic [RW-1:0]    b_rgb;

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      b_cmd <= a_cmd;
      b_p   <= PW'(a_m) * PW'(spans);
      b_idx <= a_idx;
      b_rgb <= a_rgb;
    end
  end

  // stage C: segment, fraction, palette read (or palette write)
  logic [CNT_W:0]     seg_raw;
  logic               last_span;
  logic [AW-1:0]      seg;
  logic [MB-1:0]      frac;
  logic               wr_en;

  always_comb begin
    seg_raw   = b_p[PW-1:FRAC_BITS];
    last_span = seg_raw >= {1'b0, spans};
    // top end: last span with a full fraction lands exactly on the last entry
    seg  = last_span ? AW'(spans - CNT_W'(1)) : AW'(seg_raw);
    frac = last_span ? ONE_M : {1'b0, b_p[FRAC_BITS-1:0]};
    wr_en = b_v && rdy_c && (b_cmd == CMD_WRITE)
            && (32'(b_idx) < PALETTE_DEPTH);
  end

  logic [RW-1:0] rd_lo, rd_hi;

  pgi_ram #(
    .WIDTH (RW),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (AW'(b_idx)),
    .wdata   (b_rgb),
    .re      (rdy_c),
    .raddr_a (seg),
    .raddr_b (seg + AW'(1)),
    .rdata_a (rd_lo),
    .rdata_b (rd_hi)
  );

  logic          c_cmd;
  logic [MB-1:0] c_frac;

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      c_cmd  <= b_cmd;
      c_frac <= frac;
    end
  end

  // stages D and E live in the lanes; writes leave the pipe here
  pgi_adv_t adv;
  assign adv.d = rdy_d;
  assign adv.e = rdy_e;

  logic [CH_W-1:0] res_r, res_g, res_b;

  pgi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_r (
    .clk    (clk),
    .adv    (adv),
    .lo     (rd_lo[CH_W-1:0]),
    .hi     (rd_hi[CH_W-1:0]),
    .frac   (c_frac),
    .result (res_r)
  );

  pgi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_g (
    .clk    (clk),
    .adv    (adv),
    .lo     (rd_lo[2*CH_W-1:CH_W]),
    .hi     (rd_hi[2*CH_W-1:CH_W]),
    .frac   (c_frac),
    .result (res_g)
  );

  pgi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_b (
    .clk    (clk),
    .adv    (adv),
    .lo     (rd_lo[3*CH_W-1:2*CH_W]),
    .hi     (rd_hi[3*CH_W-1:2*CH_W]),
    .frac   (c_frac),
    .result (res_b)
  );

  assign m_tdata = {(M_TDATA_W - RW)'(0), res_b, res_g, res_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
    end else begin
      if (rdy_a) a_v <= s_tvalid;
      if (rdy_b) b_v <= a_v;
      if (rdy_c) c_v <= b_v;
      if (rdy_d) d_v <= c_v && (c_cmd == CMD_LOOKUP);
      if (rdy_e) e_v <= d_v;
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking stream testbench for the palette gradient interpolator unit.
module tb_top
  import pgi_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE             = 1 << FRAC_BITS_DEF;
  localparam int IDX_LO          = MAG_W;
  localparam int RED_LO          = MAG_W + IDX_W;
  localparam int GREEN_LO        = RED_LO + CH_W;
  localparam int BLUE_LO         = GREEN_LO + CH_W;
  localparam int DIR_ROWS        = 25;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int SETTLE_CYCLES   = 8;       // pipeline is five deep
  localparam int LIMIT_CYCLES    = 500000;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef enum logic {ROW_ITEM, ROW_MODE} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic              cmd;
    logic [MAG_W-1:0]  mag;
    logic [IDX_W-1:0]  idx;
    rgb_t              chan;
    logic              known;
    rgb_t              want;
    logic              cyc;
    logic [CNT_W-1:0]  cnt;
  } dir_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_CHOKE} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = CMD_LOOKUP;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_CYCLIC;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Sideband travelling with each item: a hand-typed expected color.
  logic                  item_known = 1'b0;
  rgb_t                  item_want = '0;

  // Predictor state.
  logic [CH_W-1:0]       pal_red   [PALETTE_DEPTH_DEF];
  logic [CH_W-1:0]       pal_green [PALETTE_DEPTH_DEF];
  logic [CH_W-1:0]       pal_blue  [PALETTE_DEPTH_DEF];
  logic                  mode_cyclic = 1'b0;
  logic [CNT_W-1:0]      mode_count = CNT_W'(COUNT_RESET);

  rgb_t                  color_q [$];
  int                    errors = 0;
  int unsigned           cycles = 0;
  int                    burst_left = 0;
  rx_mode_t              rx_mode = RX_OPEN;
  int                    rx_left = 0;
  dir_row_t              dir_tab [DIR_ROWS];

  palette_gradient_interpolator_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("palette_gradient_interpolator_unit regression: fail");
      $finish;
    end
  end

  // Receiver back pressure: a mode is held for a while, then another is drawn.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(32, 256);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:    m_tready <= 1'b1;
      RX_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
      RX_PATTERN: m_tready <= ((cycles % 5) < 2);
      default:    m_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  function automatic int eff_count(input logic [CNT_W-1:0] cnt);
    int c;
    c = cnt;
    if (c < 2) c = 2;
    if (c > PALETTE_DEPTH_DEF) c = PALETTE_DEPTH_DEF;
    return c;
  endfunction

  function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] a,
                                                  input logic [CH_W-1:0] b,
                                                  input longint f);
    longint s;
    s = longint'(a) * (ONE - f) + longint'(b) * f;
    return CH_W'(s >> FRAC_BITS_DEF);
  endfunction

  function automatic rgb_t blend_color(input logic [MAG_W-1:0] mag);
    longint m, spans, p, seg, frac;
    rgb_t   c;
    m = mag[MAG_W-1] ? 0 : longint'(mag);
    if (m > ONE) m = ONE;
    if (mode_cyclic && m > ONE / 2) m = ONE - m;
    spans = eff_count(mode_count) - 1;
    p = m * spans;
    seg = p >> FRAC_BITS_DEF;
    frac = p & (ONE - 1);
    // magnitude of one lands past the last span: use its far end
    if (seg >= spans) begin
      seg = spans - 1;
      frac = ONE;
    end
    c.red   = mix_channel(pal_red[seg],   pal_red[seg + 1],   frac);
    c.green = mix_channel(pal_green[seg], pal_green[seg + 1], frac);
    c.blue  = mix_channel(pal_blue[seg],  pal_blue[seg + 1],  frac);
    return c;
  endfunction

  task automatic check_field(input string name, input logic [CH_W-1:0] want,
                             input logic [CH_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Transfer monitor: predicts on input transfers, checks output transfers.
  always @(posedge clk) begin
    logic [IDX_W-1:0] widx;
    rgb_t             want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CYCLIC) mode_cyclic = cfg_data[0];
        else if (cfg_index == CFG_COUNT) mode_count = cfg_data[CNT_W-1:0];
      end
      if (m_tvalid && m_tready) begin
        if (color_q.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, actual red %0d green %0d blue %0d",
                   $time, m_tdata[0 +: CH_W], m_tdata[CH_W +: CH_W],
                   m_tdata[2*CH_W +: CH_W]);
        end else begin
          want = color_q.pop_front();
          check_field("red",   want.red,   m_tdata[0 +: CH_W]);
          check_field("green", want.green, m_tdata[CH_W +: CH_W]);
          check_field("blue",  want.blue,  m_tdata[2*CH_W +: CH_W]);
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_WRITE) begin
          widx = s_tdata[IDX_LO +: IDX_W];
          if (int'(widx) < PALETTE_DEPTH_DEF) begin
            pal_red[widx]   = s_tdata[RED_LO +: CH_W];
            pal_green[widx] = s_tdata[GREEN_LO +: CH_W];
            pal_blue[widx]  = s_tdata[BLUE_LO +: CH_W];
          end
        end else if (item_known) begin
          color_q = {color_q, item_want};
        end else begin
          color_q = {color_q, blend_color(s_tdata[MAG_W-1:0])};
        end
      end
    end
  end

  // Sends one item; the sender sometimes idles between bursts of random length.
  task automatic push_item(input logic cmd, input logic [MAG_W-1:0] mag,
                           input logic [IDX_W-1:0] idx, input rgb_t chan,
                           input logic known, input rgb_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 64);
    end
    s_tvalid   <= 1'b1;
    s_tuser    <= cmd;
    s_tdata    <= {5'b0, chan.blue, chan.green, chan.red, idx, mag};
    item_known <= known;
    item_want  <= want;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  // Stops the sender and waits until every lookup is answered and writes settled.
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (color_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic cyc, input logic [CNT_W-1:0] cnt);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CYCLIC;
    cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, cyc};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_COUNT;
    cfg_data  <= cnt;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [MAG_W-1:0] pick_mag(input int spans);
    int sel, k, v;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      v = $urandom_range(0, ONE);
    end else if (sel < 70) begin
      v = $urandom;
    end else if (sel < 85) begin
      // around a span boundary
      k = $urandom_range(0, spans);
      v = (k * ONE) / spans + $urandom_range(0, 4) - 2;
    end else begin
      case ($urandom_range(0, 7))
        0:       v = 0;
        1:       v = 1;
        2:       v = ONE / 2;
        3:       v = ONE / 2 + 1;
        4:       v = ONE - 1;
        5:       v = ONE;
        6:       v = ONE + 1;
        default: v = -1;
      endcase
    end
    return v[MAG_W-1:0];
  endfunction

  function automatic rgb_t rand_rgb();
    rgb_t c;
    c.red   = CH_W'($urandom_range(0, 511));
    c.green = CH_W'($urandom_range(0, 511));
    c.blue  = CH_W'($urandom_range(0, 511));
    return c;
  endfunction

  function automatic dir_row_t palette_row(input logic [IDX_W-1:0] idx,
                                           input int r, input int g, input int b);
    dir_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.cmd  = CMD_WRITE;
    row.idx  = idx;
    row.chan = '{red: CH_W'(r), green: CH_W'(g), blue: CH_W'(b)};
    return row;
  endfunction

  function automatic dir_row_t lookup_row(input logic [MAG_W-1:0] mag);
    dir_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.cmd  = CMD_LOOKUP;
    row.mag  = mag;
    return row;
  endfunction

  function automatic dir_row_t lookup_known(input logic [MAG_W-1:0] mag,
                                            input int r, input int g, input int b);
    dir_row_t row;
    row = lookup_row(mag);
    row.known = 1'b1;
    row.want  = '{red: CH_W'(r), green: CH_W'(g), blue: CH_W'(b)};
    return row;
  endfunction

  function automatic dir_row_t mode_row(input logic cyc, input logic [CNT_W-1:0] cnt);
    dir_row_t row;
    row = '0;
    row.kind = ROW_MODE;
    row.cyc  = cyc;
    row.cnt  = cnt;
    return row;
  endfunction

  initial begin
    int               n, ph, i, spans;
    logic             ph_cyc;
    logic [CNT_W-1:0] ph_cnt;
    rgb_t             chan;

    // reset settings: linear, five entries over four spans
    dir_tab[0]  = palette_row(4'd0, 0, 0, 0);
    dir_tab[1]  = palette_row(4'd1, 64, 128, 256);
    dir_tab[2]  = palette_row(4'd2, 128, 256, 511);
    dir_tab[3]  = palette_row(4'd3, 256, 0, 1);
    dir_tab[4]  = palette_row(4'd4, 511, 511, 511);
    dir_tab[5]  = lookup_known(20'd0, 0, 0, 0);
    dir_tab[6]  = lookup_known(20'd65536, 511, 511, 511);
    dir_tab[7]  = lookup_known(20'h80000, 0, 0, 0);          // most negative
    dir_tab[8]  = lookup_known(20'h7FFFF, 511, 511, 511);    // most positive
    dir_tab[9]  = lookup_known(20'hFFFFF, 0, 0, 0);
    dir_tab[10] = lookup_known(20'd65537, 511, 511, 511);
    dir_tab[11] = lookup_known(20'd16384, 64, 128, 256);
    dir_tab[12] = lookup_known(20'd32768, 128, 256, 511);
    dir_tab[13] = lookup_row(20'd8192);
    dir_tab[14] = lookup_row(20'd1);
    dir_tab[15] = lookup_row(20'd65535);
    dir_tab[16] = mode_row(1'b1, 5'd5);
    dir_tab[17] = lookup_known(20'd49152, 64, 128, 256);     // mirrored to a quarter
    dir_tab[18] = lookup_known(20'd65536, 0, 0, 0);
    dir_tab[19] = lookup_row(20'd32769);
    dir_tab[20] = mode_row(1'b0, 5'd1);                     // count raised to two
    dir_tab[21] = lookup_known(20'd65536, 64, 128, 256);
    dir_tab[22] = lookup_row(20'd32768);
    dir_tab[23] = mode_row(1'b0, 5'd0);
    dir_tab[24] = lookup_known(20'h7FFFF, 64, 128, 256);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (n = 0; n < DIR_ROWS; n++) begin
      if (dir_tab[n].kind == ROW_MODE) begin
        drain();
        set_mode(dir_tab[n].cyc, dir_tab[n].cnt);
      end else begin
        push_item(dir_tab[n].cmd, dir_tab[n].mag, dir_tab[n].idx, dir_tab[n].chan,
                  dir_tab[n].known, dir_tab[n].want);
      end
    end

    // fill every entry so any later count only reads written entries
    for (i = 0; i < PALETTE_DEPTH_DEF; i++) begin
      push_item(CMD_WRITE, MAG_W'($urandom), IDX_W'(i), rand_rgb(), 1'b0, '0);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin ph_cyc = 1'b0; ph_cnt = 5'd16; end
        1:       begin ph_cyc = 1'b1; ph_cnt = 5'd16; end
        2:       begin ph_cyc = 1'b0; ph_cnt = 5'd31; end
        3:       begin ph_cyc = 1'b1; ph_cnt = 5'd17; end
        4:       begin ph_cyc = 1'b0; ph_cnt = 5'd2;  end
        5:       begin ph_cyc = 1'b1; ph_cnt = 5'd0;  end
        6:       begin ph_cyc = 1'b1; ph_cnt = 5'd2;  end
        7:       begin ph_cyc = 1'b0; ph_cnt = 5'd5;  end
        default: begin
          ph_cyc = 1'($urandom_range(0, 1));
          ph_cnt = CNT_W'($urandom_range(0, 31));
        end
      endcase
      drain();
      set_mode(ph_cyc, ph_cnt);
      spans = eff_count(ph_cnt) - 1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        chan = rand_rgb();
        if ($urandom_range(0, 4) == 0) begin
          push_item(CMD_WRITE, MAG_W'($urandom), IDX_W'($urandom), chan, 1'b0, '0);
        end else begin
          push_item(CMD_LOOKUP, pick_mag(spans), IDX_W'($urandom), chan, 1'b0, '0);
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("palette_gradient_interpolator_unit regression: pass");
    end else begin
      $display("palette_gradient_interpolator_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pgi_pkg.sv
hw/rtl/pgi_ram.sv
hw/rtl/pgi_lane.sv
hw/rtl/palette_gradient_interpolator_unit.sv
tb/tb_top.sv
